/* hw/rtl/rmst_pkg.sv */
// Shared types and constants for the range-minimum segment tree.
`timescale 1ns / 1ps
package rmst_pkg;

    localparam int POS_W   = 10;
    localparam int VALUE_W = 30;
    localparam int NODE_W  = 31;

    localparam logic [NODE_W-1:0] EMPTY_MARK = {NODE_W{1'b1}};

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Datapath commands, several may be active in one cycle.
    typedef struct packed {
        logic clr_step;
        logic up_start;
        logic up_read;
        logic up_merge;
        logic q_start;
        logic rd_l;
        logic rd_r;
        logic merge;
        logic shift;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic pos_ok;
        logic clr_last;
        logic parent_root;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic out_busy;
    } status_t;

endpackage

/* hw/rtl/rmst_in_if.sv */
// Request channel: update or query item.
`timescale 1ns / 1ps
interface rmst_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [rmst_pkg::POS_W-1:0]     position;
    logic [rmst_pkg::POS_W-1:0]     range_high;
    logic [rmst_pkg::VALUE_W-1:0]   value;

    modport source (output valid, kind, position, range_high, value, input ready);
    modport sink   (input valid, kind, position, range_high, value, output ready);
endinterface

/* hw/rtl/rmst_out_if.sv */
// Response channel: query result item.
`timescale 1ns / 1ps
interface rmst_out_if;
    logic                           valid;
    logic                           ready;
    logic [rmst_pkg::VALUE_W-1:0]   min_value;
    logic                           empty_res;

    modport source (output valid, min_value, empty_res, input ready);
    modport sink   (input valid, min_value, empty_res, output ready);
endinterface

/* hw/rtl/rmst_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rmst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/rmst_ctrl.sv */
// Sequencer for clearing, leaf update climb and range query walk.
`timescale 1ns / 1ps
module rmst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_kind,
    output logic              req_ready,
    input  rmst_pkg::status_t status,
    output rmst_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_UP_READ = 8'b0000_0100,
        S_UP_MRG  = 8'b0000_1000,
        S_Q_LEFT  = 8'b0001_0000,
        S_Q_LDATA = 8'b0010_0000,
        S_Q_RDATA = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == rmst_pkg::KIND_QUERY)
                    begin
                        cmd.q_start = 1'b1;
                        state_next  = S_Q_LEFT;
                    end
                    else if (status.pos_ok)
                    begin
                        cmd.up_start = 1'b1;
                        state_next   = S_UP_READ;
                    end
                end
            end
            S_UP_READ:
            begin
                cmd.up_read = 1'b1;
                state_next  = S_UP_MRG;
            end
            S_UP_MRG:
            begin
                cmd.up_merge = 1'b1;
                state_next   = status.parent_root ? S_IDLE : S_UP_READ;
            end
            S_Q_LEFT:
            begin
                priority if (!status.l_lt_r)
                begin
                    state_next = S_DONE;
                end
                else if (status.l_odd)
                begin
                    cmd.rd_l   = 1'b1;
                    state_next = S_Q_LDATA;
                end
                else if (status.r_odd)
                begin
                    cmd.rd_r   = 1'b1;
                    state_next = S_Q_RDATA;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            S_Q_LDATA:
            begin
                cmd.merge = 1'b1;
                if (status.r_odd)
                begin
                    cmd.rd_r   = 1'b1;
                    state_next = S_Q_RDATA;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_Q_LEFT;
                end
            end
            S_Q_RDATA:
            begin
                cmd.merge  = 1'b1;
                cmd.shift  = 1'b1;
                state_next = S_Q_LEFT;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* hw/rtl/rmst_datapath.sv */
// Node store, walk pointers, minimum units and result register.
`timescale 1ns / 1ps
module rmst_datapath #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rmst_pkg::POS_W-1:0]     position,
    input  logic [rmst_pkg::POS_W-1:0]     range_high,
    input  logic [rmst_pkg::VALUE_W-1:0]   value,
    input  rmst_pkg::cmd_t                 cmd,
    output rmst_pkg::status_t              status,
    rmst_out_if.source                     rsp
);

    localparam int LEVELS = $clog2(LEAF_COUNT);
    localparam int ADDR_W = LEVELS + 1;
    localparam int IDX_W  = LEVELS + 2;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [31:0] LEAF_BASE = 32'd1 << LEVELS;
    localparam logic [31:0] LEAF_NUM  = 32'(LEAF_COUNT);
    localparam logic [31:0] LAST_LEAF = 32'(LEAF_COUNT - 1);

    localparam int NODE_W  = rmst_pkg::NODE_W;
    localparam int VALUE_W = rmst_pkg::VALUE_W;

    logic [31:0] pos32;
    logic [31:0] hi32;
    logic [31:0] hi_sat32;
    logic [31:0] leaf32;
    logic [31:0] rend32;
    logic        range_ok;

    logic [ADDR_W-1:0]  clr_reg,  clr_next;
    logic [ADDR_W-1:0]  n_reg,    n_next;
    logic [NODE_W-1:0]  cur_reg,  cur_next;
    logic [IDX_W-1:0]   l_reg,    l_next;
    logic [IDX_W-1:0]   r_reg,    r_next;
    logic [NODE_W-1:0]  best_reg, best_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [VALUE_W-1:0] min_reg,  min_next;
    logic               empty_reg, empty_next;

    logic [IDX_W-1:0]  r_dec;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [NODE_W-1:0] ram_wdata;
    logic [NODE_W-1:0] ram_rdata;
    logic [NODE_W-1:0] up_min;
    logic [NODE_W-1:0] q_min;

    assign pos32    = 32'(position);
    assign hi32     = 32'(range_high);
    assign hi_sat32 = (hi32 > LAST_LEAF) ? LAST_LEAF : hi32;
    assign range_ok = pos32 <= hi_sat32;
    assign leaf32   = LEAF_BASE + pos32;
    assign rend32   = LEAF_BASE + hi_sat32 + 32'd1;

    assign r_dec  = r_reg - IDX_W'(1);
    assign up_min = (ram_rdata < cur_reg) ? ram_rdata : cur_reg;
    assign q_min  = (ram_rdata < best_reg) ? ram_rdata : best_reg;

    rmst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = n_reg;
        ram_wdata = rmst_pkg::EMPTY_MARK;
        priority if (cmd.clr_step)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_reg;
        end
        else if (cmd.up_start)
        begin
            ram_we    = 1'b1;
            ram_addr  = leaf32[ADDR_W-1:0];
            ram_wdata = {1'b0, value};
        end
        else if (cmd.up_read)
        begin
            ram_addr = n_reg ^ ADDR_W'(1);
        end
        else if (cmd.up_merge)
        begin
            ram_we    = 1'b1;
            ram_addr  = n_reg >> 1;
            ram_wdata = up_min;
        end
        else if (cmd.rd_l)
        begin
            ram_addr = l_reg[ADDR_W-1:0];
        end
        else if (cmd.rd_r)
        begin
            ram_addr = r_dec[ADDR_W-1:0];
        end
        else
        begin
            ram_addr = n_reg;
        end
    end

    always_comb
    begin
        clr_next       = clr_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        best_next      = best_reg;
        min_next       = min_reg;
        empty_next     = empty_reg;
        rsp_valid_next = rsp_valid_reg;

        if (cmd.clr_step)
        begin
            clr_next = clr_reg + ADDR_W'(1);
        end
        if (cmd.up_start)
        begin
            n_next   = leaf32[ADDR_W-1:0];
            cur_next = {1'b0, value};
        end
        if (cmd.up_merge)
        begin
            n_next   = n_reg >> 1;
            cur_next = up_min;
        end
        if (cmd.q_start)
        begin
            l_next    = leaf32[IDX_W-1:0];
            r_next    = range_ok ? rend32[IDX_W-1:0] : leaf32[IDX_W-1:0];
            best_next = rmst_pkg::EMPTY_MARK;
        end
        if (cmd.rd_l)
        begin
            l_next = l_reg + IDX_W'(1);
        end
        if (cmd.rd_r)
        begin
            r_next = r_dec;
        end
        if (cmd.merge)
        begin
            best_next = q_min;
        end
        if (cmd.shift)
        begin
            l_next = l_next >> 1;
            r_next = r_next >> 1;
        end

        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            rsp_valid_next = 1'b1;
            if (best_reg == rmst_pkg::EMPTY_MARK)
            begin
                min_next   = '0;
                empty_next = 1'b1;
            end
            else
            begin
                min_next   = best_reg[VALUE_W-1:0];
                empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        cur_reg   <= cur_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        best_reg  <= best_next;
        min_reg   <= min_next;
        empty_reg <= empty_next;
    end

    assign status.pos_ok      = pos32 < LEAF_NUM;
    assign status.clr_last    = clr_reg == {ADDR_W{1'b1}};
    assign status.parent_root = (n_reg >> 1) == ADDR_W'(1);
    assign status.l_lt_r      = l_reg < r_reg;
    assign status.l_odd       = l_reg[0];
    assign status.r_odd       = r_reg[0];
    assign status.out_busy    = rsp_valid_reg && !rsp.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.min_value = min_reg;
    assign rsp.empty_res = empty_reg;

endmodule

/* hw/rtl/range_min_segment_tree.sv */
// Top level of the range-minimum segment tree.
//
// req carries update items (kind 0: store value at position) and query items
// (kind 1: minimum over position..range_high, inclusive). An update gives no
// response; a query gives one rsp item with min_value, or empty_res set and
// min_value zero when no written leaf lies in the range.
// Nodes live in one single-port RAM of 2*P entries (P = LEAF_COUNT rounded up
// to a power of two); every access goes through its one port, which sets the rate.
// Update: a leaf write, then a sibling read and a parent write per level up to
// the root. Out-of-range updates are accepted and dropped without a RAM write.
// Query: after the accept, the walk climbs one level at a time, reading and
// merging each boundary node that lies in the range, until a range check finds
// the bounds met; then the result is handed over. An empty or reversed range goes straight to the handover.
// After reset all 2*P entries (2048 at the default size) are swept to the empty
// marker, one entry per cycle; req.ready stays low meanwhile.
// The result sits in an output register: a new item is accepted while it waits.
// If rsp stalls, a finished query holds until the register frees.
`timescale 1ns / 1ps
module range_min_segment_tree #(
    parameter int LEAF_COUNT = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    rmst_in_if.sink   req,
    rmst_out_if.source rsp
);

    rmst_pkg::cmd_t    cmd;
    rmst_pkg::status_t status;
    logic              ready;

    assign req.ready = ready;

    rmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (ready),
        .status    (status),
        .cmd       (cmd)
    );

    rmst_datapath #(
        .LEAF_COUNT (LEAF_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .position   (req.position),
        .range_high (req.range_high),
        .value      (req.value),
        .cmd        (cmd),
        .status     (status),
        .rsp        (rsp)
    );

endmodule

/* hw/rtl/rmst_checker.sv */
// Port-level checks for the range-minimum segment tree, bound to the top.
`timescale 1ns / 1ps
module rmst_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [rmst_pkg::VALUE_W-1:0] rsp_min_value,
    input logic                         rsp_empty_res
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_min_value) && $stable(rsp_empty_res))
        else $error("rsp payload changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_empty_res |-> rsp_min_value == '0)
        else $error("empty result with nonzero value");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared right after accepting an item");

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_min_value (rsp.min_value),
    .rsp_empty_res (rsp.empty_res)
);
